[hw/rtl/psh_pkg.sv]
// ----------------------------------------------------------------------------
// psh_pkg
// Types and constants shared by the supervisor modules.
// ----------------------------------------------------------------------------
package psh_pkg;

    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 8;
    localparam int DELTA_W   = 10;

    localparam logic [CFG_IDX_W-1:0] REG_FAIL_OUTAGE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_OUTAGE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TEST   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TEST  = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] RST_FAIL_OUTAGE = CFG_W'(10);
    localparam logic [CFG_W-1:0] RST_LONG_OUTAGE = CFG_W'(3000);
    localparam logic [CFG_W-1:0] RST_LONG_TEST   = CFG_W'(10000);
    localparam logic [CFG_W-1:0] RST_SHORT_TEST  = CFG_W'(1000);

    typedef struct packed {
        logic [DELTA_W-1:0] delta_ms;
        logic               powered;
        logic               fault_in;
        logic               engage_switch;
        logic               green_low;
        logic               blue_low;
        logic               yellow_low;
    } t_in_item;

    typedef struct packed {
        logic healthy;
        logic test_done;
        logic power_fault;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] fail_outage_ms;
        logic [CFG_W-1:0] long_outage_ms;
        logic [CFG_W-1:0] long_test_ms;
        logic [CFG_W-1:0] short_test_ms;
    } t_cfg;

    typedef struct packed {
        logic fault_latch;
        logic prev_switch;
    } t_flags;

endpackage

[hw/rtl/psh_cfg_regs.sv]
// ----------------------------------------------------------------------------
// psh_cfg_regs
// Configuration register file: limits and self-test lengths.
// ----------------------------------------------------------------------------
module psh_cfg_regs
    import psh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FAIL_OUTAGE: n_cfg.fail_outage_ms = i_cfg_data;
                REG_LONG_OUTAGE: n_cfg.long_outage_ms = i_cfg_data;
                REG_LONG_TEST:   n_cfg.long_test_ms   = i_cfg_data;
                REG_SHORT_TEST:  n_cfg.short_test_ms  = i_cfg_data;
                default:         n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fail_outage_ms <= RST_FAIL_OUTAGE;
            r_cfg.long_outage_ms <= RST_LONG_OUTAGE;
            r_cfg.long_test_ms   <= RST_LONG_TEST;
            r_cfg.short_test_ms  <= RST_SHORT_TEST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[hw/rtl/psh_step.sv]
// ----------------------------------------------------------------------------
// psh_step
// One tick of the power monitor, switch edge, test countdown and health.
// ----------------------------------------------------------------------------
module psh_step
    import psh_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  t_in_item             i_item,
    input  t_cfg                 i_cfg,
    input  logic [TIME_BITS-1:0] i_outage_acc,
    input  logic [TIME_BITS-1:0] i_test_timer,
    input  t_flags               i_flags,
    output logic [TIME_BITS-1:0] o_outage_acc,
    output logic [TIME_BITS-1:0] o_test_timer,
    output t_flags               o_flags,
    output t_out_item            o_item
);

    localparam int WW = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam logic [WW-1:0] TIME_MAX_W = WW'({TIME_BITS{1'b1}});

    logic [TIME_BITS:0]   sum;
    logic [TIME_BITS-1:0] acc1;
    logic [WW-1:0]        acc_w;
    logic                 latch1;
    logic                 latch2;
    logic                 pwr_restart;
    logic                 all_low;
    logic                 sw_load;
    logic [CFG_W-1:0]     len;
    logic [WW-1:0]        len_w;
    logic [TIME_BITS-1:0] len_sat;
    logic [TIME_BITS-1:0] delta_t;
    logic [TIME_BITS-1:0] timer1;
    logic [TIME_BITS-1:0] timer2;
    logic                 complete;

    always_comb begin
        delta_t = TIME_BITS'(i_item.delta_ms);
        sum     = {1'b0, i_outage_acc} + {1'b0, delta_t};
        if (i_item.powered) begin
            acc1 = i_outage_acc;
        end else if (sum[TIME_BITS]) begin
            acc1 = '1;
        end else begin
            acc1 = sum[TIME_BITS-1:0];
        end
        acc_w = WW'(acc1);

        latch1      = i_flags.fault_latch | (acc_w > WW'(i_cfg.fail_outage_ms));
        pwr_restart = i_item.powered & latch1;
        latch2      = latch1 & ~i_item.powered;

        all_low = i_item.green_low & i_item.blue_low & i_item.yellow_low;
        sw_load = i_item.engage_switch & ~i_flags.prev_switch & ~latch2;

        if (sw_load) begin
            len = all_low ? i_cfg.long_test_ms : i_cfg.short_test_ms;
        end else if (all_low && (acc_w > WW'(i_cfg.long_outage_ms))) begin
            len = i_cfg.long_test_ms;
        end else begin
            len = i_cfg.short_test_ms;
        end
        len_w   = WW'(len);
        len_sat = (len_w > TIME_MAX_W) ? '1 : TIME_BITS'(len_w);

        timer1   = (sw_load || pwr_restart) ? len_sat : i_test_timer;
        timer2   = (timer1 > delta_t) ? (timer1 - delta_t) : '0;
        complete = (timer2 == '0);

        o_outage_acc        = pwr_restart ? '0 : acc1;
        o_test_timer        = timer2;
        o_flags.fault_latch = latch2;
        o_flags.prev_switch = i_item.engage_switch;

        o_item.healthy     = ~i_item.fault_in & ~latch2 & complete & i_item.engage_switch;
        o_item.test_done   = complete;
        o_item.power_fault = latch2;
    end

endmodule

[hw/rtl/power_selftest_health_supervisor.sv]
// ----------------------------------------------------------------------------
// power_selftest_health_supervisor
// Power outage monitor, self-test timer and health flag, one result per tick.
// ----------------------------------------------------------------------------
// Each tick item gives exactly one result item. An accepted item is held in an
// input register until the result register can take it; then the tick logic
// updates the outage accumulator, fault latch, switch history and test timer
// and loads the result register, from which the result item is presented. A
// new tick is taken every cycle while the result side keeps up. Configuration
// writes take effect on the next cycle and are ignored for unknown indexes.
module power_selftest_health_supervisor
    import psh_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_item             i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_item            o_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg                 cfg;
    t_in_item             r_in;
    logic                 r_in_valid;
    logic                 r_out_valid;
    t_out_item            r_out;
    logic [TIME_BITS-1:0] r_outage_acc;
    logic [TIME_BITS-1:0] r_test_timer;
    t_flags               r_flags;
    logic [TIME_BITS-1:0] n_outage_acc;
    logic [TIME_BITS-1:0] n_test_timer;
    t_flags               n_flags;
    t_out_item            n_out;
    logic                 advance;

    psh_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    psh_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .i_item       (r_in),
        .i_cfg        (cfg),
        .i_outage_acc (r_outage_acc),
        .i_test_timer (r_test_timer),
        .i_flags      (r_flags),
        .o_outage_acc (n_outage_acc),
        .o_test_timer (n_test_timer),
        .o_flags      (n_flags),
        .o_item       (n_out)
    );

    assign advance = r_in_valid & (~r_out_valid | i_ready);
    assign o_ready = ~r_in_valid | advance;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_outage_acc <= '0;
            r_test_timer <= '0;
            r_flags      <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_outage_acc <= n_outage_acc;
                r_test_timer <= n_test_timer;
                r_flags      <= n_flags;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_fault_not_healthy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_item.healthy && o_item.power_fault))
        else $error("healthy reported with power fault latched");

    a_healthy_needs_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.healthy) |-> o_item.test_done)
        else $error("healthy reported before self-test completed");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("stalled item dropped from input register");

    a_result_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_ready && !advance) |=> !r_out_valid)
        else $error("result repeated after being taken");

    a_power_clears_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.powered) |=> !r_flags.fault_latch)
        else $error("power fault latch held with power present");

endmodule

[tb/sv/psh_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psh_result_checker
// Watches the tick, result and register channels of the supervisor, predicts
// each result from its own copy of the outage, fault, switch and timer state
// and compares every result item, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module psh_result_checker
    import psh_pkg::*;
#(
    parameter int TIME_BITS = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick_valid,
    input  logic                 i_tick_ready,
    input  t_in_item             i_tick_item,
    input  logic                 i_result_valid,
    input  logic                 i_result_ready,
    input  t_out_item            i_result_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int REPORT_LIMIT = 10;
    localparam logic [TIME_BITS-1:0] TIME_SAT = '1;

    t_cfg                 limits;
    logic [TIME_BITS-1:0] outage_ms;
    logic                 fault_latched;
    logic [TIME_BITS-1:0] test_left_ms;
    logic                 switch_was_on;
    t_out_item            expected_results[$];
    int                   result_count;

    function automatic logic [TIME_BITS-1:0] test_length(input logic from_switch,
                                                         input logic all_low);
        logic [CFG_W-1:0] len;
        if (all_low && (outage_ms > limits.long_outage_ms || from_switch)) begin
            len = limits.long_test_ms;
        end else begin
            len = limits.short_test_ms;
        end
        return (64'(len) > 64'(TIME_SAT)) ? TIME_SAT : TIME_BITS'(len);
    endfunction

    function automatic t_out_item predict_tick(input t_in_item it);
        logic [TIME_BITS:0] sum;
        logic               all_low;
        t_out_item          res;
        all_low = it.green_low && it.blue_low && it.yellow_low;
        if (!it.powered) begin
            sum = {1'b0, outage_ms} + (TIME_BITS+1)'(it.delta_ms);
            outage_ms = (sum > {1'b0, TIME_SAT}) ? TIME_SAT : sum[TIME_BITS-1:0];
        end
        if (outage_ms > limits.fail_outage_ms) begin
            fault_latched = 1'b1;
        end
        if (it.powered && fault_latched) begin
            fault_latched = 1'b0;
            test_left_ms  = test_length(1'b0, all_low);
            outage_ms     = '0;
        end
        if (it.engage_switch && !switch_was_on && !fault_latched) begin
            test_left_ms = test_length(1'b1, all_low);
        end
        switch_was_on = it.engage_switch;
        if (test_left_ms > TIME_BITS'(it.delta_ms)) begin
            test_left_ms = test_left_ms - TIME_BITS'(it.delta_ms);
        end else begin
            test_left_ms = '0;
        end
        res.test_done   = (test_left_ms == '0);
        res.power_fault = fault_latched;
        res.healthy     = !it.fault_in && !fault_latched && res.test_done
                          && it.engage_switch;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            limits.fail_outage_ms = RST_FAIL_OUTAGE;
            limits.long_outage_ms = RST_LONG_OUTAGE;
            limits.long_test_ms   = RST_LONG_TEST;
            limits.short_test_ms  = RST_SHORT_TEST;
            outage_ms     = '0;
            fault_latched = 1'b0;
            test_left_ms  = '0;
            switch_was_on = 1'b0;
            result_count  = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_FAIL_OUTAGE: limits.fail_outage_ms = i_cfg_data;
                    REG_LONG_OUTAGE: limits.long_outage_ms = i_cfg_data;
                    REG_LONG_TEST:   limits.long_test_ms   = i_cfg_data;
                    REG_SHORT_TEST:  limits.short_test_ms  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_tick_valid && i_tick_ready) begin
                expected_results.push_back(predict_tick(i_tick_item));
            end
            if (i_result_valid && i_result_ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("ERROR: result %0d arrived with nothing outstanding: %b",
                                 result_count, i_result_item);
                    end
                end else begin
                    exp_item = expected_results.pop_front();
                    if (i_result_item.healthy !== exp_item.healthy
                            || i_result_item.test_done !== exp_item.test_done
                            || i_result_item.power_fault !== exp_item.power_fault) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display("ERROR: result %0d expected %b/%b/%b got %b/%b/%b",
                                     result_count, exp_item.healthy, exp_item.test_done,
                                     exp_item.power_fault, i_result_item.healthy,
                                     i_result_item.test_done, i_result_item.power_fault);
                        end
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[tb/sv/tb_power_selftest_health_supervisor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_selftest_health_supervisor
// Drives directed and random ticks and register settings into the supervisor
// with bursty input and a stalling result side, and reports the verdict of
// the result checker.
// ----------------------------------------------------------------------------
module tb_power_selftest_health_supervisor;
    import psh_pkg::*;

    localparam int TB_TIME_BITS    = 20;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 6;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_TICKS     = 70;
    localparam int SATURATE_TICKS  = 1030;
    localparam int PHASE_SATURATE  = 2;
    localparam int PHASE_HOLD      = 3;
    localparam int IN_W            = $bits(t_in_item);

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;
    localparam logic [DELTA_W-1:0]   DELTA_MAX        = '1;

    typedef enum int {RX_FREE, RX_BUSY, RX_SPARSE} t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 tick_valid;
    logic                 tick_ready;
    t_in_item             tick_item;
    logic                 result_valid;
    logic                 result_ready;
    t_out_item            result_item;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;

    logic     hold_req;
    logic     hold_seen;
    int       idle_cycles;
    int       gen_outage_left;
    logic     gen_switch;
    t_rx_mode rx_mode;
    int       rx_phase_left;
    int       rx_hold_left;

    power_selftest_health_supervisor #(
        .TIME_BITS(TB_TIME_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (tick_valid),
        .o_ready    (tick_ready),
        .i_item     (tick_item),
        .o_valid    (result_valid),
        .i_ready    (result_ready),
        .o_item     (result_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    psh_result_checker #(
        .TIME_BITS(TB_TIME_BITS)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick_valid  (tick_valid),
        .i_tick_ready  (tick_ready),
        .i_tick_item   (tick_item),
        .i_result_valid(result_valid),
        .i_result_ready(result_ready),
        .i_result_item (result_item),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial i_clk = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_valid && tick_ready) || (result_valid && result_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        result_ready  = 1'b0;
        hold_seen     = 1'b0;
        rx_mode       = RX_FREE;
        rx_phase_left = 0;
        rx_hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen    = hold_req;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                result_ready = 1'b0;
                rx_hold_left--;
            end else begin
                if (rx_phase_left == 0) begin
                    case ($urandom_range(0, 2))
                        0: rx_mode = RX_FREE;
                        1: rx_mode = RX_BUSY;
                        default: rx_mode = RX_SPARSE;
                    endcase
                    rx_phase_left = $urandom_range(16, 160);
                end
                rx_phase_left--;
                case (rx_mode)
                    RX_FREE: result_ready = 1'b1;
                    RX_BUSY: result_ready = ($urandom_range(0, 3) != 0);
                    default: result_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic t_in_item make_tick(input logic [DELTA_W-1:0] delta, input logic pw,
                                           input logic flt, input logic sw, input logic g,
                                           input logic b, input logic y);
        t_in_item it;
        it.delta_ms      = delta;
        it.powered       = pw;
        it.fault_in      = flt;
        it.engage_switch = sw;
        it.green_low     = g;
        it.blue_low      = b;
        it.yellow_low    = y;
        return it;
    endfunction

    task automatic send_tick(input t_in_item it);
        tick_valid = 1'b1;
        tick_item  = it;
        do @(posedge i_clk); while (!tick_ready);
        @(negedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        tick_valid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        tick_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic apply_limits(input t_cfg c);
        write_reg(REG_UNUSED_FIRST, CFG_W'($urandom));
        write_reg(REG_FAIL_OUTAGE, c.fail_outage_ms);
        write_reg(REG_LONG_OUTAGE, c.long_outage_ms);
        write_reg(REG_LONG_TEST, c.long_test_ms);
        write_reg(REG_SHORT_TEST, c.short_test_ms);
        write_reg(REG_UNUSED_LAST, CFG_W'($urandom));
        cfg_valid = 1'b0;
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic next_tick(output t_in_item it);
        logic [IN_W-1:0] raw;
        raw = IN_W'($urandom);
        if ($urandom_range(0, 99) < 8) begin
            it = raw;
        end else begin
            if (gen_outage_left == 0 && $urandom_range(0, 99) < 6) begin
                gen_outage_left = $urandom_range(1, 25);
            end
            if ($urandom_range(0, 9) == 0) begin
                gen_switch = !gen_switch;
            end
            it.powered = (gen_outage_left == 0);
            if (gen_outage_left > 0) begin
                gen_outage_left--;
            end
            case ($urandom_range(0, 19))
                0: it.delta_ms = '0;
                1: it.delta_ms = DELTA_MAX;
                2, 3: it.delta_ms = DELTA_W'($urandom_range(0, 1023));
                default: it.delta_ms = DELTA_W'($urandom_range(1, 80));
            endcase
            it.fault_in      = ($urandom_range(0, 9) == 0);
            it.engage_switch = gen_switch;
            if ($urandom_range(0, 9) < 4) begin
                {it.green_low, it.blue_low, it.yellow_low} = 3'b111;
            end else begin
                {it.green_low, it.blue_low, it.yellow_low} = raw[2:0];
            end
        end
    endtask

    initial begin
        t_in_item it;
        t_cfg     lim;
        int       sent;
        int       burst;
        tick_valid      = 1'b0;
        tick_item       = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        hold_req        = 1'b0;
        gen_outage_left = 0;
        gen_switch      = 1'b0;
        i_rst_n         = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        send_tick(make_tick(0, 1, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 1, 0, 1, 0, 0, 0));
        send_tick(make_tick(DELTA_MAX, 1, 0, 1, 1, 1, 1));
        send_tick(make_tick(0, 1, 1, 1, 1, 1, 1));
        send_tick(make_tick(0, 1, 0, 0, 1, 1, 1));
        send_tick(make_tick(0, 1, 0, 1, 1, 1, 1));
        send_tick(make_tick(DELTA_MAX, 1, 0, 1, 0, 1, 1));
        send_tick(make_tick(5, 0, 0, 1, 0, 0, 0));
        send_tick(make_tick(0, 1, 0, 1, 0, 0, 0));
        send_tick(make_tick(6, 0, 0, 1, 0, 0, 0));
        send_tick(make_tick(DELTA_MAX, 0, 1, 0, 1, 0, 1));
        send_tick(make_tick(DELTA_MAX, 0, 0, 1, 1, 1, 1));
        send_tick(make_tick(DELTA_MAX, 0, 0, 0, 0, 0, 0));
        send_tick(make_tick(0, 1, 0, 0, 1, 1, 1));
        send_tick(make_tick(DELTA_MAX, 1, 0, 1, 1, 1, 1));
        send_tick(make_tick(DELTA_MAX, 0, 0, 1, 0, 0, 1));
        send_tick(make_tick(0, 1, 0, 1, 0, 1, 1));
        send_tick(make_tick(DELTA_MAX, 1, 0, 1, 0, 0, 0));
        send_tick(make_tick(DELTA_MAX, 1, 1, 1, 1, 1, 1));
        send_tick(make_tick(0, 0, 0, 0, 0, 0, 0));
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: lim = {RST_FAIL_OUTAGE, RST_LONG_OUTAGE, RST_LONG_TEST, RST_SHORT_TEST};
                1: lim = '0;
                2: lim = '1;
                3: lim = {CFG_W'(50), CFG_W'(200), CFG_W'(800), CFG_W'(150)};
                4: lim = {CFG_W'(2000), CFG_W'(100), CFG_W'(3000), CFG_W'(500)};
                default: begin
                    lim.fail_outage_ms = CFG_W'($urandom_range(0, 3000));
                    lim.long_outage_ms = CFG_W'($urandom_range(0, 5000));
                    lim.long_test_ms   = CFG_W'($urandom_range(0, 6000));
                    lim.short_test_ms  = CFG_W'($urandom_range(0, 1500));
                end
            endcase
            apply_limits(lim);

            // drive the outage total into saturation
            if (phase == PHASE_SATURATE) begin
                repeat (SATURATE_TICKS) begin
                    next_tick(it);
                    it.powered  = 1'b0;
                    it.delta_ms = DELTA_MAX;
                    send_tick(it);
                end
            end

            sent = 0;
            while (sent < PHASE_TICKS) begin
                burst = $urandom_range(1, 24);
                repeat (burst) begin
                    if (sent < PHASE_TICKS) begin
                        next_tick(it);
                        send_tick(it);
                        sent++;
                        if (phase == PHASE_HOLD && sent == 40) begin
                            hold_req = ~hold_req;
                        end
                    end
                end
                if ($urandom_range(0, 3) != 0) begin
                    pause_sender($urandom_range(1, 10));
                end
            end
            wait_drained();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/psh_pkg.sv
hw/rtl/psh_cfg_regs.sv
hw/rtl/psh_step.sv
hw/rtl/power_selftest_health_supervisor.sv
tb/sv/psh_result_checker.sv
tb/sv/tb_power_selftest_health_supervisor.sv
